### rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, constants and helper functions for the affine TRS compose
// pipeline: sine table generation, quadrant codes and Q16.16 saturation.
// ----------------------------------------------------------------------------
package atc_pkg;

    // Quarter-wave sine table
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH);
    localparam int ANGLE_W          = 16;
    localparam int PHASE_W          = ANGLE_W - 2;
    localparam int PHASE_PROD_W     = PHASE_W + SIN_IDX_W;

    // Table entries are unsigned 17 bits (0 .. 65536); trig values signed 18 bits
    localparam int ENTRY_W = 17;
    localparam int TRIG_W  = ENTRY_W + 1;

    localparam logic [ENTRY_W-1:0]       ENTRY_ONE = ENTRY_W'(65536);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE  = TRIG_W'(65536);

    // Datapath widths
    localparam int Q_W       = 32;
    localparam int LPROD_W   = Q_W + TRIG_W;       // scale x trig product
    localparam int WIDE_W    = 50;                 // rounded sums before saturation
    localparam int PPROD_W   = 2 * Q_W;            // parent x local product
    localparam int SUM_W     = PPROD_W + 2;        // exact sum of two products
    localparam int FRAC_W    = 16;
    localparam int NUM_STAGES = 6;
    localparam int NUM_OUT    = 6;

    // Half an LSB of Q16.16, for round half up
    localparam logic [FRAC_W-1:0] HALF_LSB = 16'h8000;

    // Angle of a quarter turn
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

    // Quadrant codes, angle[15:14]
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef logic [ENTRY_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Half pi in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // One table entry: Q30 Taylor series to x^15, terms truncated,
    // then rounded half up to Q16.16 and capped at one.
    function automatic logic [ENTRY_W-1:0] sine_entry(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (unsigned'(sum) + 64'd8192) >> 14;
        if (v > 64'd65536)
        begin
            v = 64'd65536;
        end
        return v[ENTRY_W-1:0];
    endfunction

    // Whole table, entries 0 .. depth-1; entry depth is always one
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat_q32(input logic signed [WIDE_W-1:0] v);
        logic ovf;
        ovf = (v[WIDE_W-1:Q_W-1] != '0) && (v[WIDE_W-1:Q_W-1] != '1);
        if (ovf)
        begin
            return {v[WIDE_W-1], {(Q_W-1){~v[WIDE_W-1]}}};
        end
        return v[Q_W-1:0];
    endfunction

endpackage

### rtl/atc_sincos.sv
// ----------------------------------------------------------------------------
// atc_sincos
// Quarter-wave table lookup of sine and cosine for a 16-bit binary angle.
// Combinational; the caller registers the result.
// ----------------------------------------------------------------------------
module atc_sincos
    import atc_pkg::*;
(
    input  logic [ANGLE_W-1:0]       angle,
    output logic signed [TRIG_W-1:0] sin_val,
    output logic signed [TRIG_W-1:0] cos_val
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [PHASE_PROD_W-1:0]  phase_prod;
    logic [SIN_IDX_W-1:0]     idx;
    logic [SIN_IDX_W-1:0]     idx_comp;
    logic [ENTRY_W-1:0]       t_fwd;
    logic [ENTRY_W-1:0]       t_rev;
    logic signed [TRIG_W-1:0] s_fwd;
    logic signed [TRIG_W-1:0] s_rev;
    quad_t                    quad;

    // Table index from the phase within the quadrant
    assign phase_prod = PHASE_PROD_W'(angle[PHASE_W-1:0]) * PHASE_PROD_W'(SINE_TABLE_DEPTH);
    assign idx        = phase_prod[PHASE_PROD_W-1 -: SIN_IDX_W];
    assign idx_comp   = SIN_IDX_W'(SINE_TABLE_DEPTH - int'(idx));
    assign quad       = quad_t'(angle[ANGLE_W-1 -: 2]);

    // Forward entry T[i], reflected entry T[depth - i] (one at i = 0)
    assign t_fwd = SINE_ROM[idx];
    assign t_rev = (idx == '0) ? ENTRY_ONE : SINE_ROM[idx_comp];
    assign s_fwd = signed'({1'b0, t_fwd});
    assign s_rev = signed'({1'b0, t_rev});

    // Quadrant folding
    always_comb
    begin
        case (quad)
            QUAD_0:
            begin
                sin_val = s_fwd;
                cos_val = s_rev;
            end
            QUAD_1:
            begin
                sin_val = s_rev;
                cos_val = -s_fwd;
            end
            QUAD_2:
            begin
                sin_val = -s_fwd;
                cos_val = -s_rev;
            end
            default:
            begin
                sin_val = -s_rev;
                cos_val = s_fwd;
            end
        endcase
    end

endmodule

### rtl/affine_trs_compose_top.sv
// ----------------------------------------------------------------------------
// affine_trs_compose_top
// Builds a node's local rotate-scale-translate matrix and premultiplies it
// by the parent 2x3 affine matrix, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer is accepted every cycle unless a stalled
// output has filled the pipeline. Stages: sine/cosine lookup, the four
// scale-by-trig products, rounding and saturation of the local matrix, the
// twelve 32x32 parent products, exact pairwise sums with rounding, and
// translation add with final saturation into the output register. Each
// stage carries its own valid bit and holds while the stage after it is
// full and blocked, so bubbles are squeezed out and a stalled output does
// not stop input transfers until the pipeline is full.
module affine_trs_compose_top
    import atc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ANGLE_W-1:0]       angle,
    input  logic signed [Q_W-1:0]    scale_x,
    input  logic signed [Q_W-1:0]    scale_y,
    input  logic signed [Q_W-1:0]    translate_x,
    input  logic signed [Q_W-1:0]    translate_y,
    input  logic signed [Q_W-1:0]    parent_a,
    input  logic signed [Q_W-1:0]    parent_b,
    input  logic signed [Q_W-1:0]    parent_c,
    input  logic signed [Q_W-1:0]    parent_d,
    input  logic signed [Q_W-1:0]    parent_e,
    input  logic signed [Q_W-1:0]    parent_f,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [Q_W-1:0]    out_a,
    output logic signed [Q_W-1:0]    out_b,
    output logic signed [Q_W-1:0]    out_c,
    output logic signed [Q_W-1:0]    out_d,
    output logic signed [Q_W-1:0]    out_e,
    output logic signed [Q_W-1:0]    out_f
);

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] valid_up;
    logic [NUM_STAGES-1:0] load;

    // Valid feeding each stage and whether each stage can take it
    always_comb
    begin
        valid_up[0] = in_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_up[k] = valid_reg[k-1];
        end
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            valid_next[k] = stage_ready[k] ? valid_up[k] : valid_reg[k];
            load[k]       = stage_ready[k] && valid_up[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: sine and cosine lookup
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] nsin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [Q_W-1:0]    sx1_reg;
    logic signed [Q_W-1:0]    sy1_reg;
    logic signed [Q_W-1:0]    tx1_reg;
    logic signed [Q_W-1:0]    ty1_reg;
    logic signed [Q_W-1:0]    par1_reg [NUM_OUT];

    atc_sincos u_sincos (
        .angle   (angle),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            sin_reg     <= sin_val;
            nsin_reg    <= -sin_val;
            cos_reg     <= cos_val;
            sx1_reg     <= scale_x;
            sy1_reg     <= scale_y;
            tx1_reg     <= translate_x;
            ty1_reg     <= translate_y;
            par1_reg[0] <= parent_a;
            par1_reg[1] <= parent_b;
            par1_reg[2] <= parent_c;
            par1_reg[3] <= parent_d;
            par1_reg[4] <= parent_e;
            par1_reg[5] <= parent_f;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by trig products
    // ------------------------------------------------------------------
    logic signed [LPROD_W-1:0] lp_a_reg;
    logic signed [LPROD_W-1:0] lp_b_reg;
    logic signed [LPROD_W-1:0] lp_d_reg;
    logic signed [LPROD_W-1:0] lp_e_reg;
    logic signed [Q_W-1:0]     tx2_reg;
    logic signed [Q_W-1:0]     ty2_reg;
    logic signed [Q_W-1:0]     par2_reg [NUM_OUT];

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            lp_a_reg <= sx1_reg * cos_reg;
            lp_b_reg <= sy1_reg * nsin_reg;
            lp_d_reg <= sx1_reg * sin_reg;
            lp_e_reg <= sy1_reg * cos_reg;
            tx2_reg  <= tx1_reg;
            ty2_reg  <= ty1_reg;
            par2_reg <= par1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round half up and saturate the local matrix
    // ------------------------------------------------------------------
    logic signed [WIDE_W-1:0] rnd_a;
    logic signed [WIDE_W-1:0] rnd_b;
    logic signed [WIDE_W-1:0] rnd_d;
    logic signed [WIDE_W-1:0] rnd_e;
    logic signed [Q_W-1:0]    la_reg;
    logic signed [Q_W-1:0]    lb_reg;
    logic signed [Q_W-1:0]    ld_reg;
    logic signed [Q_W-1:0]    le_reg;
    logic signed [Q_W-1:0]    tx3_reg;
    logic signed [Q_W-1:0]    ty3_reg;
    logic signed [Q_W-1:0]    par3_reg [NUM_OUT];

    assign rnd_a = WIDE_W'(lp_a_reg) + WIDE_W'(HALF_LSB);
    assign rnd_b = WIDE_W'(lp_b_reg) + WIDE_W'(HALF_LSB);
    assign rnd_d = WIDE_W'(lp_d_reg) + WIDE_W'(HALF_LSB);
    assign rnd_e = WIDE_W'(lp_e_reg) + WIDE_W'(HALF_LSB);

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            la_reg   <= sat_q32(rnd_a >>> FRAC_W);
            lb_reg   <= sat_q32(rnd_b >>> FRAC_W);
            ld_reg   <= sat_q32(rnd_d >>> FRAC_W);
            le_reg   <= sat_q32(rnd_e >>> FRAC_W);
            tx3_reg  <= tx2_reg;
            ty3_reg  <= ty2_reg;
            par3_reg <= par2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: parent x local products, two per output entry
    // ------------------------------------------------------------------
    logic signed [PPROD_W-1:0] px_reg [NUM_OUT];
    logic signed [PPROD_W-1:0] py_reg [NUM_OUT];
    logic signed [Q_W-1:0]     pc4_reg;
    logic signed [Q_W-1:0]     pf4_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            // row 0 uses parent a, b; row 1 uses parent d, e
            px_reg[0] <= par3_reg[0] * la_reg;
            py_reg[0] <= par3_reg[1] * ld_reg;
            px_reg[1] <= par3_reg[0] * lb_reg;
            py_reg[1] <= par3_reg[1] * le_reg;
            px_reg[2] <= par3_reg[0] * tx3_reg;
            py_reg[2] <= par3_reg[1] * ty3_reg;
            px_reg[3] <= par3_reg[3] * la_reg;
            py_reg[3] <= par3_reg[4] * ld_reg;
            px_reg[4] <= par3_reg[3] * lb_reg;
            py_reg[4] <= par3_reg[4] * le_reg;
            px_reg[5] <= par3_reg[3] * tx3_reg;
            py_reg[5] <= par3_reg[4] * ty3_reg;
            pc4_reg   <= par3_reg[2];
            pf4_reg   <= par3_reg[5];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: exact pair sums, rounded half up to Q16.16
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  pair_sum [NUM_OUT];
    logic signed [WIDE_W-1:0] dot_reg  [NUM_OUT];
    logic signed [Q_W-1:0]    pc5_reg;
    logic signed [Q_W-1:0]    pf5_reg;

    always_comb
    begin
        for (int j = 0; j < NUM_OUT; j++)
        begin
            pair_sum[j] = SUM_W'(px_reg[j]) + SUM_W'(py_reg[j]) + SUM_W'(HALF_LSB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            for (int j = 0; j < NUM_OUT; j++)
            begin
                dot_reg[j] <= pair_sum[j][FRAC_W +: WIDE_W];
            end
            pc5_reg <= pc4_reg;
            pf5_reg <= pf4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: add parent translation, saturate, output register
    // ------------------------------------------------------------------
    logic signed [WIDE_W-1:0] tot_c;
    logic signed [WIDE_W-1:0] tot_f;
    logic signed [Q_W-1:0]    out_a_reg;
    logic signed [Q_W-1:0]    out_b_reg;
    logic signed [Q_W-1:0]    out_c_reg;
    logic signed [Q_W-1:0]    out_d_reg;
    logic signed [Q_W-1:0]    out_e_reg;
    logic signed [Q_W-1:0]    out_f_reg;

    assign tot_c = dot_reg[2] + WIDE_W'(pc5_reg);
    assign tot_f = dot_reg[5] + WIDE_W'(pf5_reg);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            out_a_reg <= sat_q32(dot_reg[0]);
            out_b_reg <= sat_q32(dot_reg[1]);
            out_c_reg <= sat_q32(tot_c);
            out_d_reg <= sat_q32(dot_reg[3]);
            out_e_reg <= sat_q32(dot_reg[4]);
            out_f_reg <= sat_q32(tot_f);
        end
    end

    assign out_a = out_a_reg;
    assign out_b = out_b_reg;
    assign out_c = out_c_reg;
    assign out_d = out_d_reg;
    assign out_e = out_e_reg;
    assign out_f = out_f_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A full stage whose successor is blocked keeps its item
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg & ~stage_ready) != '0 |=>
        ($past(valid_reg & ~stage_ready) & ~valid_reg) == '0)
        else $error("pipeline stage dropped a stalled item");

    // Free output means the whole ready chain is open
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is free");

    // Zero angle gives sin 0, cos 1
    a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && angle == '0 |=>
        sin_reg == '0 && cos_reg == TRIG_ONE)
        else $error("wrong sine/cosine at zero angle");

    // Quarter turn gives sin 1, cos 0
    a_angle_quarter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && angle == QUARTER_TURN |=>
        sin_reg == TRIG_ONE && cos_reg == '0)
        else $error("wrong sine/cosine at quarter turn");

endmodule
